/* hw/rtl/mcsp_pkg.sv */
// ----------------------------------------------------------------------------
// mcsp_pkg
// Shared types, codes and sizes of the MIDI chord slot player.
// ----------------------------------------------------------------------------
package mcsp_pkg;

	// Sizes
	localparam int SLOTS    = 8;
	localparam int CHANNELS = 16;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * SLOTS;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENTRY_W  = 14;

	localparam logic [3:0] SLOTS_L    = 4'(SLOTS);
	localparam logic [4:0] CHANNELS_L = 5'(CHANNELS);

	// MIDI constants
	localparam logic [7:0] STAT_HI_MASK = 8'hF0;
	localparam logic [7:0] STAT_NOTE_ON = 8'h90;
	localparam logic [7:0] STAT_NOTE_OF = 8'h80;
	localparam logic [7:0] STAT_META    = 8'hFF;
	localparam logic [7:0] META_EOT     = 8'h2F;

	typedef enum logic [1:0] {
		FUNC_SCORE   = 2'd0,
		FUNC_PRESS   = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_NOTE_ON  = 3'd0,
		KIND_NOTE_OFF = 3'd1,
		KIND_STOP     = 3'd2,
		KIND_STATUS   = 3'd3,
		KIND_REJECT   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_KEY,
		ST_STATUS
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic load;
		logic scan_step;
		logic key_step;
		logic note_on_wr;
		logic set_ended;
		logic emit_stop;
		logic emit_reject;
		logic emit_status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		func_t func;
		logic  ended;
		logic  eot;
		logic  note_on;
		logic  note_off;
		logic  note_ev;
		logic  ch_ok;
		logic  key_ch_ok;
		logic  slot_ok;
		logic  scan_hit;
		logic  at_last;
	} stat_t;

endpackage

/* hw/rtl/mcsp_ctrl.sv */
// ----------------------------------------------------------------------------
// mcsp_ctrl
// Sequencer: decodes each item and steps the datapath over the slots.
// ----------------------------------------------------------------------------
module mcsp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mcsp_pkg::stat_t st,
	output mcsp_pkg::cmd_t  cmd
);

	mcsp_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mcsp_pkg::ST_IDLE: begin
				if (start) state_nxt = mcsp_pkg::ST_DECODE;
			end
			mcsp_pkg::ST_DECODE: begin
				if (st.func == mcsp_pkg::FUNC_SCORE) begin
					priority if (st.ended || st.eot) state_nxt = mcsp_pkg::ST_STATUS;
					else if (!st.ch_ok) begin
						state_nxt = st.note_ev ? mcsp_pkg::ST_IDLE : mcsp_pkg::ST_STATUS;
					end
					else if (st.note_off) state_nxt = mcsp_pkg::ST_SCAN;
					else state_nxt = mcsp_pkg::ST_STATUS;
				end else begin
					priority if (!st.key_ch_ok) state_nxt = mcsp_pkg::ST_IDLE;
					else if (st.func == mcsp_pkg::FUNC_CLEAR) state_nxt = mcsp_pkg::ST_KEY;
					else if (!st.slot_ok) state_nxt = mcsp_pkg::ST_IDLE;
					else state_nxt = mcsp_pkg::ST_KEY;
				end
			end
			mcsp_pkg::ST_SCAN: begin
				if (st.scan_hit || st.at_last) state_nxt = mcsp_pkg::ST_STATUS;
			end
			mcsp_pkg::ST_KEY: begin
				if (st.at_last) state_nxt = mcsp_pkg::ST_IDLE;
			end
			mcsp_pkg::ST_STATUS: begin
				state_nxt = mcsp_pkg::ST_IDLE;
			end
			default: state_nxt = mcsp_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != mcsp_pkg::ST_IDLE);
		unique case (state_q)
			mcsp_pkg::ST_IDLE: begin
				cmd.capture = start;
			end
			mcsp_pkg::ST_DECODE: begin
				if (st.func == mcsp_pkg::FUNC_SCORE) begin
					priority if (st.ended) begin
						cmd = '0;
					end else if (st.eot) begin
						cmd.emit_stop = 1'b1;
						cmd.set_ended = 1'b1;
					end else if (!st.ch_ok) begin
						cmd.emit_reject = st.note_ev;
					end else if (st.note_off) begin
						cmd.load = 1'b1;
					end else if (st.note_on) begin
						cmd.note_on_wr = 1'b1;
					end else begin
						cmd = '0;
					end
				end else begin
					priority if (!st.key_ch_ok) begin
						cmd.emit_reject = 1'b1;
					end else if (st.func == mcsp_pkg::FUNC_CLEAR) begin
						cmd.load = 1'b1;
					end else if (!st.slot_ok) begin
						cmd.emit_reject = 1'b1;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			mcsp_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			mcsp_pkg::ST_KEY: begin
				cmd.key_step = 1'b1;
			end
			mcsp_pkg::ST_STATUS: begin
				cmd.emit_status = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

/* hw/rtl/mcsp_datapath.sv */
// ----------------------------------------------------------------------------
// mcsp_datapath
// Item registers, slot valid bits, slot note memories and the result register.
// ----------------------------------------------------------------------------
module mcsp_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcsp_pkg::cmd_t                 cmd,
	output mcsp_pkg::stat_t                st,
	input  logic [1:0]                     func,
	input  logic [7:0]                     midi_status,
	input  logic [6:0]                     first_data,
	input  logic [6:0]                     second_data,
	input  logic [7:0]                     meta_code,
	input  logic [3:0]                     key_slot,
	input  logic                           all_slots,
	input  logic [4:0]                     key_channel,
	output logic                           strobe,
	output logic [2:0]                     kind,
	output logic [6:0]                     note_number,
	output logic [6:0]                     note_velocity,
	output logic [4:0]                     out_channel,
	output logic                           changed,
	output logic                           has_assigned,
	output logic                           last
);

	// Captured item
	mcsp_pkg::func_t              func_q;
	logic [7:0]                   status_q;
	logic [6:0]                   d1_q;
	logic [6:0]                   d2_q;
	logic [7:0]                   meta_q;
	logic [3:0]                   kslot_q;
	logic                         all_q;
	logic [4:0]                   kch_q;

	// Slot state
	logic [mcsp_pkg::SLOTS-1:0]   asg_vld_q [mcsp_pkg::CHANNELS];
	logic [mcsp_pkg::SLOTS-1:0]   ply_vld_q [mcsp_pkg::CHANNELS];
	logic [mcsp_pkg::ENTRY_W-1:0] asg_mem   [mcsp_pkg::DEPTH];
	logic [mcsp_pkg::ENTRY_W-1:0] ply_mem   [mcsp_pkg::DEPTH];
	logic [mcsp_pkg::ENTRY_W-1:0] asg_rd_q;
	logic [mcsp_pkg::ENTRY_W-1:0] ply_rd_q;
	logic                         ended_q;
	logic                         chg_q;
	logic [mcsp_pkg::SLOT_W-1:0]  slot_q;

	// Decode
	logic [7:0]                   stat_hi;
	logic                         on_raw;
	logic [mcsp_pkg::CH_W-1:0]    ch;
	logic [4:0]                   score_chan;
	logic                         full_range;
	logic [mcsp_pkg::SLOT_W-1:0]  lo_slot;
	logic [mcsp_pkg::SLOT_W-1:0]  last_slot;
	logic [mcsp_pkg::SLOT_W-1:0]  next_slot;
	logic [mcsp_pkg::ADDR_W-1:0]  base;
	logic [mcsp_pkg::ADDR_W-1:0]  rd_addr;
	logic [mcsp_pkg::ADDR_W-1:0]  cur_addr;
	logic [mcsp_pkg::ADDR_W-1:0]  free_addr;
	logic [mcsp_pkg::SLOTS-1:0]   asg_row;
	logic [mcsp_pkg::SLOTS-1:0]   ply_row;
	logic [mcsp_pkg::SLOTS-1:0]   sel_row;
	logic [mcsp_pkg::SLOTS-1:0]   above;
	logic [mcsp_pkg::ENTRY_W-1:0] sel_data;
	logic [mcsp_pkg::SLOT_W-1:0]  free_slot;
	logic                         free_found;
	logic                         is_press;
	logic                         has_any;
	logic                         key_emit;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= mcsp_pkg::func_t'(func);
			status_q <= midi_status;
			d1_q     <= first_data;
			d2_q     <= second_data;
			meta_q   <= meta_code;
			kslot_q  <= key_slot;
			all_q    <= all_slots;
			kch_q    <= key_channel;
		end
	end

	assign stat_hi    = status_q & mcsp_pkg::STAT_HI_MASK;
	assign on_raw     = (stat_hi == mcsp_pkg::STAT_NOTE_ON);
	assign score_chan = {1'b0, status_q[3:0]} + 5'd1;
	assign ch         = (func_q == mcsp_pkg::FUNC_SCORE) ?
		mcsp_pkg::CH_W'(status_q[3:0]) : mcsp_pkg::CH_W'(kch_q - 5'd1);
	assign is_press   = (func_q == mcsp_pkg::FUNC_PRESS);
	assign full_range = (func_q == mcsp_pkg::FUNC_SCORE) || (func_q == mcsp_pkg::FUNC_CLEAR)
		|| all_q;
	assign lo_slot    = full_range ? '0 : mcsp_pkg::SLOT_W'(kslot_q);
	assign last_slot  = full_range ? mcsp_pkg::SLOT_W'(mcsp_pkg::SLOTS - 1)
		: mcsp_pkg::SLOT_W'(kslot_q);
	assign next_slot  = cmd.load ? lo_slot : mcsp_pkg::SLOT_W'(slot_q + 1'b1);

	assign base      = mcsp_pkg::ADDR_W'(ch * mcsp_pkg::SLOTS);
	assign rd_addr   = base + mcsp_pkg::ADDR_W'(next_slot);
	assign cur_addr  = base + mcsp_pkg::ADDR_W'(slot_q);
	assign free_addr = base + mcsp_pkg::ADDR_W'(free_slot);

	assign asg_row  = asg_vld_q[ch];
	assign ply_row  = ply_vld_q[ch];
	assign sel_row  = is_press ? asg_row : ply_row;
	assign sel_data = is_press ? asg_rd_q : ply_rd_q;
	assign has_any  = st.ch_ok && (|asg_row);
	assign key_emit = cmd.key_step && sel_row[slot_q];

	// Lowest free assigned slot
	always_comb begin
		free_slot  = '0;
		free_found = 1'b0;
		for (int j = mcsp_pkg::SLOTS - 1; j >= 0; j--) begin
			if (!asg_row[j]) begin
				free_slot  = mcsp_pkg::SLOT_W'(j);
				free_found = 1'b1;
			end
		end
	end

	// Slots after the current one, within the range
	always_comb begin
		for (int j = 0; j < mcsp_pkg::SLOTS; j++) begin
			above[j] = (mcsp_pkg::SLOT_W'(j) > slot_q) && (mcsp_pkg::SLOT_W'(j) <= last_slot);
		end
	end

	always_comb begin
		st.func      = func_q;
		st.ended     = ended_q;
		st.eot       = (status_q == mcsp_pkg::STAT_META) && (meta_q == mcsp_pkg::META_EOT);
		st.note_on   = on_raw && (d2_q != 7'd0);
		st.note_off  = (stat_hi == mcsp_pkg::STAT_NOTE_OF) || (on_raw && (d2_q == 7'd0));
		st.note_ev   = (stat_hi == mcsp_pkg::STAT_NOTE_OF) || on_raw;
		st.ch_ok     = {1'b0, status_q[3:0]} < mcsp_pkg::CHANNELS_L;
		st.key_ch_ok = (kch_q != 5'd0) && (kch_q <= mcsp_pkg::CHANNELS_L);
		st.slot_ok   = all_q || (kslot_q < mcsp_pkg::SLOTS_L);
		st.scan_hit  = asg_row[slot_q] && (asg_rd_q[13:7] == d1_q);
		st.at_last   = (slot_q == last_slot);
	end

	// Slot memories
	always_ff @(posedge clk) begin
		asg_rd_q <= asg_mem[rd_addr];
		if (cmd.note_on_wr && free_found) asg_mem[free_addr] <= {d1_q, d2_q};
	end

	always_ff @(posedge clk) begin
		ply_rd_q <= ply_mem[rd_addr];
		if (cmd.key_step && is_press && asg_row[slot_q]) ply_mem[cur_addr] <= asg_rd_q;
	end

	// Valid bits and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < mcsp_pkg::CHANNELS; c++) begin
				asg_vld_q[c] <= '0;
				ply_vld_q[c] <= '0;
			end
			ended_q <= 1'b0;
			chg_q   <= 1'b0;
			slot_q  <= '0;
		end else begin
			if (cmd.capture) chg_q <= 1'b0;
			if (cmd.set_ended) ended_q <= 1'b1;
			if (cmd.load || cmd.scan_step || cmd.key_step) slot_q <= next_slot;
			if (cmd.note_on_wr && free_found) begin
				asg_vld_q[ch][free_slot] <= 1'b1;
				chg_q                    <= 1'b1;
			end
			if (cmd.scan_step && st.scan_hit) begin
				asg_vld_q[ch][slot_q] <= 1'b0;
				chg_q                 <= 1'b1;
			end
			if (cmd.key_step) begin
				unique case (func_q)
					mcsp_pkg::FUNC_PRESS: begin
						if (asg_row[slot_q]) ply_vld_q[ch][slot_q] <= 1'b1;
					end
					mcsp_pkg::FUNC_CLEAR: begin
						ply_vld_q[ch][slot_q] <= 1'b0;
						asg_vld_q[ch][slot_q] <= 1'b0;
					end
					mcsp_pkg::FUNC_RELEASE,
					mcsp_pkg::FUNC_SCORE: begin
						ply_vld_q[ch][slot_q] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit_stop || cmd.emit_reject || cmd.emit_status || key_emit;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_stop) begin
			kind          <= mcsp_pkg::KIND_STOP;
			note_number   <= 7'd0;
			note_velocity <= 7'd0;
			out_channel   <= score_chan;
			changed       <= 1'b0;
			has_assigned  <= 1'b0;
			last          <= 1'b0;
		end else if (cmd.emit_reject) begin
			kind          <= mcsp_pkg::KIND_REJECT;
			note_number   <= 7'd0;
			note_velocity <= 7'd0;
			out_channel   <= (func_q == mcsp_pkg::FUNC_SCORE) ? score_chan : kch_q;
			changed       <= 1'b0;
			has_assigned  <= 1'b0;
			last          <= 1'b1;
		end else if (cmd.emit_status) begin
			kind          <= mcsp_pkg::KIND_STATUS;
			note_number   <= 7'd0;
			note_velocity <= 7'd0;
			out_channel   <= score_chan;
			changed       <= chg_q;
			has_assigned  <= has_any;
			last          <= 1'b1;
		end else if (key_emit) begin
			kind          <= is_press ? mcsp_pkg::KIND_NOTE_ON : mcsp_pkg::KIND_NOTE_OFF;
			note_number   <= sel_data[13:7];
			note_velocity <= sel_data[6:0];
			out_channel   <= kch_q;
			changed       <= 1'b0;
			has_assigned  <= 1'b0;
			last          <= ~|(sel_row & above);
		end else begin
			kind <= kind;
		end
	end

endmodule

/* hw/rtl/midi_chord_slot_player.sv */
// ----------------------------------------------------------------------------
// midi_chord_slot_player
// Per-channel assigned and playing note slots driven by score and key items.
// ----------------------------------------------------------------------------
// Pulse start with an item while busy is low; the item is taken on that edge.
// Results come out one per cycle on strobe and cannot be held off, so sample
// them on every cycle strobe is high; last marks the final result of an item,
// and an item may also give no result at all (nothing to play or release).
// From the accept edge until busy drops: a score event is decoded and then
// reports its status, end of track gives the stop and then the status, a
// note-off or zero-velocity note-on searches the slots (reading one stored slot
// a cycle through the single read port of the slot memory) before the status,
// a rejected item ends in decode, and a key press, key release or clear steps
// over the slots in range (all for all slots or clear, one otherwise). Slot
// valid bits are reset flip-flops, so the block is ready straight out of reset.
// ----------------------------------------------------------------------------
module midi_chord_slot_player (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [7:0] midi_status,
	input  logic [6:0] first_data,
	input  logic [6:0] second_data,
	input  logic [7:0] meta_code,
	input  logic [3:0] key_slot,
	input  logic       all_slots,
	input  logic [4:0] key_channel,
	output logic       strobe,
	output logic [2:0] kind,
	output logic [6:0] note_number,
	output logic [6:0] note_velocity,
	output logic [4:0] out_channel,
	output logic       changed,
	output logic       has_assigned,
	output logic       last
);

	// Command and status between sequencer and datapath
	mcsp_pkg::cmd_t  cmd;
	mcsp_pkg::stat_t st;

	// Sequencer: decode the item, then step over its slots
	mcsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// Datapath: hold the item, the slot state and the result beat
	mcsp_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.func          (func),
		.midi_status   (midi_status),
		.first_data    (first_data),
		.second_data   (second_data),
		.meta_code     (meta_code),
		.key_slot      (key_slot),
		.all_slots     (all_slots),
		.key_channel   (key_channel),
		.strobe        (strobe),
		.kind          (kind),
		.note_number   (note_number),
		.note_velocity (note_velocity),
		.out_channel   (out_channel),
		.changed       (changed),
		.has_assigned  (has_assigned),
		.last          (last)
	);

endmodule

/* hw/rtl/mcsp_checker.sv */
// ----------------------------------------------------------------------------
// mcsp_checker
// Port-level checks of the MIDI chord slot player.
// ----------------------------------------------------------------------------
module mcsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [2:0] kind,
	input logic       changed,
	input logic       has_assigned,
	input logic       last
);

	// An accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accept");

	// A result beat only follows a busy cycle
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without work");

	// Stop is always followed by a status beat
	a_stop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == mcsp_pkg::KIND_STOP) |-> !last ##1 (strobe &&
		(kind == mcsp_pkg::KIND_STATUS) && last))
		else $error("stop not followed by final status");

	// A reject result is always the last result of its item
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == mcsp_pkg::KIND_REJECT) |-> last)
		else $error("reject not final");

	// Note beats carry no status flags
	a_note_flags: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && ((kind == mcsp_pkg::KIND_NOTE_ON) || (kind == mcsp_pkg::KIND_NOTE_OFF))
		|-> !changed && !has_assigned)
		else $error("note beat with status flags");

endmodule

bind midi_chord_slot_player mcsp_checker u_mcsp_checker (.*);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for midi_chord_slot_player. A scoreboard predicts every
// result from the accepted command beats and compares each strobed result,
// field by field, in order. Stimulus is a short directed list followed by
// random score events and key actions that crowd a few channels, then the
// end of track and a handful of commands after it.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mcsp_pkg::*;

	// Watchdog limit, in cycles without any accepted beat or strobed result
	localparam int QUIET_LIMIT = 2000;
	// Settle time after the last expected result, in cycles
	localparam int DRAIN_CYCLES = 4 * SLOTS;

	// One command as presented on the input ports
	typedef struct {
		func_t      func;
		logic [7:0] status;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [7:0] meta;
		logic [3:0] slot;
		logic       all;
		logic [4:0] chan;
	} slot_cmd_t;

	// One result as strobed on the output ports
	typedef struct {
		kind_t      kind;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [4:0] chan;
		logic       changed;
		logic       has_notes;
		logic       last;
	} note_result_t;

	// One stored note slot
	typedef struct {
		logic       valid;
		logic [6:0] note;
		logic [6:0] velocity;
	} note_slot_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] func = '0;
	logic [7:0] midi_status = '0;
	logic [6:0] first_data = '0;
	logic [6:0] second_data = '0;
	logic [7:0] meta_code = '0;
	logic [3:0] key_slot = '0;
	logic       all_slots = 1'b0;
	logic [4:0] key_channel = '0;
	logic       strobe;
	logic [2:0] kind;
	logic [6:0] note_number;
	logic [6:0] note_velocity;
	logic [4:0] out_channel;
	logic       changed;
	logic       has_assigned;
	logic       last;

	slot_cmd_t    pending_cmds[$];
	note_result_t expected_notes[$];
	note_slot_t   assigned_notes[128];
	note_slot_t   playing_notes[128];
	logic         track_done = 1'b0;

	logic took_beat = 1'b0;
	int   beats_sent = 0;
	int   quiet_cycles = 0;
	int   fail_count = 0;

	midi_chord_slot_player dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.midi_status  (midi_status),
		.first_data   (first_data),
		.second_data  (second_data),
		.meta_code    (meta_code),
		.key_slot     (key_slot),
		.all_slots    (all_slots),
		.key_channel  (key_channel),
		.strobe       (strobe),
		.kind         (kind),
		.note_number  (note_number),
		.note_velocity(note_velocity),
		.out_channel  (out_channel),
		.changed      (changed),
		.has_assigned (has_assigned),
		.last         (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Command builders: fill the fields the command ignores with noise
	// ------------------------------------------------------------------
	function automatic slot_cmd_t score_cmd(logic [7:0] sb, logic [6:0] nn,
			logic [6:0] vel, logic [7:0] mc);
		slot_cmd_t c;
		c.func     = FUNC_SCORE;
		c.status   = sb;
		c.note     = nn;
		c.velocity = vel;
		c.meta     = mc;
		c.slot     = 4'($urandom);
		c.all      = 1'($urandom);
		c.chan     = 5'($urandom);
		return c;
	endfunction

	function automatic slot_cmd_t key_cmd(func_t f, logic [4:0] kch, logic [3:0] ks,
			logic every);
		slot_cmd_t c;
		c.func     = f;
		c.status   = 8'($urandom);
		c.note     = 7'($urandom);
		c.velocity = 7'($urandom);
		c.meta     = 8'($urandom);
		c.slot     = ks;
		c.all      = every;
		c.chan     = kch;
		return c;
	endfunction

	function automatic note_result_t make_result(kind_t k, logic [6:0] nn,
			logic [6:0] vel, logic [4:0] ch, logic chg, logic has);
		note_result_t r;
		r.kind      = k;
		r.note      = nn;
		r.velocity  = vel;
		r.chan      = ch;
		r.changed   = chg;
		r.has_notes = has;
		r.last      = 1'b0;
		return r;
	endfunction

	function automatic logic channel_has_notes(int ch);
		logic found;
		found = 1'b0;
		for (int s = 0; s < SLOTS; s++)
			if (assigned_notes[7'(ch * SLOTS + s)].valid)
				found = 1'b1;
		return found;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard predictor: update the slot image for one accepted beat
	// and queue the results it should cause, last flag on the final one
	// ------------------------------------------------------------------
	task automatic predict_slot_results(input slot_cmd_t c);
		note_result_t outs[$];
		logic [7:0]   hi;
		int           ch;
		int           lo_s;
		int           hi_s;
		logic         chg;
		logic         note_ev;
		logic [6:0]   idx;
		ch  = int'(c.status[3:0]);
		hi  = c.status & STAT_HI_MASK;
		chg = 1'b0;
		if (c.func == FUNC_SCORE) begin
			if (track_done) begin
				// after the end of track score events only report status
				outs.push_back(make_result(KIND_STATUS, '0, '0, 5'(ch + 1), 1'b0,
					(ch < CHANNELS) ? channel_has_notes(ch) : 1'b0));
			end else if (c.status == STAT_META && c.meta == META_EOT) begin
				// end of track: stop first, then the channel status
				track_done = 1'b1;
				outs.push_back(make_result(KIND_STOP, '0, '0, 5'(ch + 1), 1'b0, 1'b0));
				outs.push_back(make_result(KIND_STATUS, '0, '0, 5'(ch + 1), 1'b0,
					(ch < CHANNELS) ? channel_has_notes(ch) : 1'b0));
			end else begin
				// a note-on with zero velocity is a note-off
				if (hi == STAT_NOTE_ON && c.velocity == '0)
					hi = STAT_NOTE_OF;
				note_ev = (hi == STAT_NOTE_OF) || (hi == STAT_NOTE_ON);
				if (ch >= CHANNELS) begin
					if (note_ev)
						outs.push_back(make_result(KIND_REJECT, '0, '0, 5'(ch + 1), 1'b0, 1'b0));
					else
						outs.push_back(make_result(KIND_STATUS, '0, '0, 5'(ch + 1), 1'b0, 1'b0));
				end else begin
					for (int s = 0; s < SLOTS; s++) begin
						idx = 7'(ch * SLOTS + s);
						if (!chg && hi == STAT_NOTE_OF && assigned_notes[idx].valid &&
								assigned_notes[idx].note == c.note) begin
							// free the first slot holding this note
							assigned_notes[idx] = '{1'b0, '0, '0};
							chg = 1'b1;
						end else if (!chg && hi == STAT_NOTE_ON && !assigned_notes[idx].valid) begin
							// take the first free slot
							assigned_notes[idx] = '{1'b1, c.note, c.velocity};
							chg = 1'b1;
						end
					end
					outs.push_back(make_result(KIND_STATUS, '0, '0, 5'(ch + 1), chg,
						channel_has_notes(ch)));
				end
			end
		end else if (c.chan < 5'd1 || c.chan > CHANNELS_L) begin
			outs.push_back(make_result(KIND_REJECT, '0, '0, c.chan, 1'b0, 1'b0));
		end else if (c.func == FUNC_CLEAR) begin
			// silence whatever plays, then empty both slot sets
			for (int s = 0; s < SLOTS; s++) begin
				idx = 7'((int'(c.chan) - 1) * SLOTS + s);
				if (playing_notes[idx].valid)
					outs.push_back(make_result(KIND_NOTE_OFF, playing_notes[idx].note,
						playing_notes[idx].velocity, c.chan, 1'b0, 1'b0));
				playing_notes[idx]  = '{1'b0, '0, '0};
				assigned_notes[idx] = '{1'b0, '0, '0};
			end
		end else if (!c.all && c.slot >= SLOTS_L) begin
			outs.push_back(make_result(KIND_REJECT, '0, '0, c.chan, 1'b0, 1'b0));
		end else begin
			lo_s = c.all ? 0 : int'(c.slot);
			hi_s = c.all ? SLOTS : int'(c.slot) + 1;
			for (int s = lo_s; s < hi_s; s++) begin
				idx = 7'((int'(c.chan) - 1) * SLOTS + s);
				if (c.func == FUNC_PRESS) begin
					// overwrite a slot already playing, no note-off for it
					if (assigned_notes[idx].valid) begin
						outs.push_back(make_result(KIND_NOTE_ON, assigned_notes[idx].note,
							assigned_notes[idx].velocity, c.chan, 1'b0, 1'b0));
						playing_notes[idx] = assigned_notes[idx];
					end
				end else if (playing_notes[idx].valid) begin
					outs.push_back(make_result(KIND_NOTE_OFF, playing_notes[idx].note,
						playing_notes[idx].velocity, c.chan, 1'b0, 1'b0));
					playing_notes[idx] = '{1'b0, '0, '0};
				end
			end
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i])
			expected_notes.push_back(outs[i]);
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: change inputs on the falling edge; advance to the next
	// command once the current beat was taken, or idle now and then
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		slot_cmd_t nx;
		logic      hold;
		if (arst_n && (!start || took_beat)) begin
			// keep a long quiet-free stretch in the middle of the run
			hold = (beats_sent < 150 || beats_sent >= 250) && ($urandom_range(0, 99) < 10);
			if (pending_cmds.size() > 0 && !hold) begin
				nx = pending_cmds.pop_front();
				func        <= nx.func;
				midi_status <= nx.status;
				first_data  <= nx.note;
				second_data <= nx.velocity;
				meta_code   <= nx.meta;
				key_slot    <= nx.slot;
				all_slots   <= nx.all;
				key_channel <= nx.chan;
				start       <= 1'b1;
				beats_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample on the rising edge. Check strobed results against
	// the oldest expectation, then predict for a beat taken on this edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		note_result_t exp_r;
		slot_cmd_t    seen;
		took_beat <= arst_n && start && !busy;
		if (arst_n) begin
			if (strobe) begin
				if (expected_notes.size() == 0) begin
					$error("unexpected result: kind %0d channel %0d", kind, out_channel);
					fail_count++;
				end else begin
					exp_r = expected_notes.pop_front();
					check_field("kind", int'(exp_r.kind), int'(kind));
					check_field("note_number", int'(exp_r.note), int'(note_number));
					check_field("note_velocity", int'(exp_r.velocity), int'(note_velocity));
					check_field("out_channel", int'(exp_r.chan), int'(out_channel));
					check_field("changed", int'(exp_r.changed), int'(changed));
					check_field("has_assigned", int'(exp_r.has_notes), int'(has_assigned));
					check_field("last", int'(exp_r.last), int'(last));
				end
			end
			if (start && !busy) begin
				seen.func     = func_t'(func);
				seen.status   = midi_status;
				seen.note     = first_data;
				seen.velocity = second_data;
				seen.meta     = meta_code;
				seen.slot     = key_slot;
				seen.all      = all_slots;
				seen.chan     = key_channel;
				predict_slot_results(seen);
			end
			// watchdog: count cycles with no beat and no result
			if ((start && !busy) || strobe)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and run control
	// ------------------------------------------------------------------
	initial begin
		slot_cmd_t  c;
		int         roll;
		int         ch;
		logic [6:0] pitch;
		logic [6:0] vel;

		// Empty slot image, as after reset
		foreach (assigned_notes[i]) begin
			assigned_notes[i] = '{1'b0, '0, '0};
			playing_notes[i]  = '{1'b0, '0, '0};
		end

		// Directed: extremes of note and velocity, zero-velocity note-on,
		// note-off with no match, non-note events and a meta event
		pending_cmds.push_back(score_cmd(STAT_NOTE_ON, 7'd0, 7'd127, 8'h00));
		pending_cmds.push_back(score_cmd(STAT_NOTE_ON, 7'd127, 7'd1, 8'h2F));
		pending_cmds.push_back(score_cmd(STAT_NOTE_ON | 8'h0F, 7'd64, 7'd64, 8'hFF));
		pending_cmds.push_back(score_cmd(STAT_NOTE_OF, 7'd5, 7'd33, 8'h00));
		pending_cmds.push_back(score_cmd(STAT_NOTE_ON, 7'd0, 7'd0, 8'h00));
		pending_cmds.push_back(score_cmd(8'hB0, 7'd7, 7'd100, 8'h00));
		pending_cmds.push_back(score_cmd(STAT_META, 7'd0, 7'd0, 8'h51));
		pending_cmds.push_back(score_cmd(8'h00, 7'd0, 7'd0, META_EOT));
		// Key actions: all slots, an empty slot, a re-press over a playing slot
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd1, 4'd0, 1'b1));
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd1, 4'd0, 1'b0));
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd16, 4'd0, 1'b0));
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd1, 4'd1, 1'b0));
		// Rejects: slot out of range, channel zero and above the last one
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd1, 4'd8, 1'b0));
		pending_cmds.push_back(key_cmd(FUNC_RELEASE, 5'd2, 4'd15, 1'b0));
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd0, 4'd0, 1'b1));
		pending_cmds.push_back(key_cmd(FUNC_RELEASE, 5'd17, 4'd0, 1'b1));
		pending_cmds.push_back(key_cmd(FUNC_CLEAR, 5'd31, 4'd15, 1'b0));
		pending_cmds.push_back(key_cmd(FUNC_RELEASE, 5'd1, 4'd15, 1'b1));
		pending_cmds.push_back(key_cmd(FUNC_CLEAR, 5'd16, 4'd0, 1'b0));
		// Fill one channel past its slots, play all of it, then clear it
		for (int k = 0; k < SLOTS + 1; k++)
			pending_cmds.push_back(score_cmd(STAT_NOTE_ON | 8'h02, 7'(10 + k),
				7'(90 + k), 8'h00));
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd3, 4'd0, 1'b1));
		pending_cmds.push_back(key_cmd(FUNC_CLEAR, 5'd3, 4'd0, 1'b0));

		// Random: mostly well-formed traffic on a few busy channels
		for (int n = 0; n < 330; n++) begin
			roll  = $urandom_range(0, 99);
			ch    = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
			pitch = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(60, 67)) : 7'($urandom);
			vel   = 7'($urandom_range(1, 127));
			if (roll < 40) begin
				c = score_cmd(STAT_NOTE_ON | 8'(ch), pitch, vel, 8'($urandom));
			end else if (roll < 60) begin
				// release a note either way MIDI allows
				if ($urandom_range(0, 1) != 0)
					c = score_cmd(STAT_NOTE_OF | 8'(ch), pitch, 7'($urandom), 8'($urandom));
				else
					c = score_cmd(STAT_NOTE_ON | 8'(ch), pitch, 7'd0, 8'($urandom));
			end else if (roll < 75) begin
				c = key_cmd(FUNC_PRESS, 5'(ch + 1), 4'($urandom_range(0, SLOTS - 1)),
					1'($urandom));
			end else if (roll < 87) begin
				c = key_cmd(FUNC_RELEASE, 5'(ch + 1), 4'($urandom_range(0, SLOTS - 1)),
					1'($urandom));
			end else if (roll < 90) begin
				c = key_cmd(FUNC_CLEAR, 5'(ch + 1), 4'($urandom), 1'($urandom));
			end else begin
				// noise: any value in every field, but hold back the end of track
				c = key_cmd(func_t'($urandom_range(0, 3)), 5'($urandom), 4'($urandom),
					1'($urandom));
				if (c.func == FUNC_SCORE && c.status == STAT_META && c.meta == META_EOT)
					c.meta = 8'h2E;
			end
			pending_cmds.push_back(c);
		end

		// End of track, then score events that must no longer change anything
		pending_cmds.push_back(score_cmd(STAT_META, 7'($urandom), 7'($urandom), META_EOT));
		pending_cmds.push_back(score_cmd(STAT_META, 7'd0, 7'd0, META_EOT));
		pending_cmds.push_back(score_cmd(STAT_NOTE_ON | 8'h03, 7'd61, 7'd77, 8'h00));
		pending_cmds.push_back(score_cmd(STAT_NOTE_OF | 8'h00, 7'd60, 7'd0, 8'h00));
		pending_cmds.push_back(key_cmd(FUNC_PRESS, 5'd4, 4'd0, 1'b1));
		pending_cmds.push_back(key_cmd(FUNC_RELEASE, 5'd4, 4'd0, 1'b1));
		pending_cmds.push_back(key_cmd(FUNC_CLEAR, 5'd1, 4'd0, 1'b0));

		// Hold reset, then release it on a falling edge, away from the rising edge
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Drain: every command taken, every result seen, then settle
		while (pending_cmds.size() > 0 || start)
			@(posedge clk);
		while (expected_notes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/mcsp_pkg.sv
hw/rtl/mcsp_ctrl.sv
hw/rtl/mcsp_datapath.sv
hw/rtl/midi_chord_slot_player.sv
hw/rtl/mcsp_checker.sv
bench/tb_top.sv
